/* rtl/flm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flm_pkg: shared types and constants of the formula lexer
// result word layout, front-to-back command word, function name table
// ----------------------------------------------------------------------------
package flm_pkg;

	localparam int KIND_W  = 2;
	localparam int CLS_W   = 3;
	localparam int FID_W   = 5;
	localparam int START_W = 16;
	localparam int LEN_W   = 16;
	localparam int CHAR_W  = 16;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_TOKEN = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ERROR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

	// token classes
	localparam logic [CLS_W-1:0] CLS_VALUE   = 3'd0;
	localparam logic [CLS_W-1:0] CLS_FUNC    = 3'd1;
	localparam logic [CLS_W-1:0] CLS_COMPARE = 3'd2;
	localparam logic [CLS_W-1:0] CLS_ADD     = 3'd3;
	localparam logic [CLS_W-1:0] CLS_MUL     = 3'd4;
	localparam logic [CLS_W-1:0] CLS_POWER   = 3'd5;
	localparam logic [CLS_W-1:0] CLS_BRACKET = 3'd6;
	localparam logic [CLS_W-1:0] CLS_SEP     = 3'd7;

	// function name table, ids are index + 1
	localparam int FN_COUNT = 18;
	localparam int FN_MAX   = 5;

	localparam logic [2:0] FN_LEN [FN_COUNT] = '{
		3'd4, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4,
		3'd4, 3'd4, 3'd4, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd4
	};

	localparam logic [7:0] FN_CHARS [FN_COUNT][FN_MAX] = '{
		'{"s", "q", "r", "t", 8'h00},
		'{"l", "o", "g", 8'h00, 8'h00},
		'{"l", "n", 8'h00, 8'h00, 8'h00},
		'{"s", "i", "n", 8'h00, 8'h00},
		'{"c", "o", "s", 8'h00, 8'h00},
		'{"t", "a", "n", 8'h00, 8'h00},
		'{"s", "i", "n", "h", 8'h00},
		'{"c", "o", "s", "h", 8'h00},
		'{"t", "a", "n", "h", 8'h00},
		'{"a", "s", "i", "n", 8'h00},
		'{"a", "c", "o", "s", 8'h00},
		'{"a", "t", "a", "n", 8'h00},
		'{"a", "b", "s", 8'h00, 8'h00},
		'{"c", "e", "i", "l", 8'h00},
		'{"f", "l", "o", "o", "r"},
		'{"s", "u", "m", 8'h00, 8'h00},
		'{"m", "u", "l", "t", 8'h00},
		'{"d", "a", "t", "a", 8'h00}
	};

	// one outgoing word
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [CLS_W-1:0]   cls;
		logic [FID_W-1:0]   fid;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
		logic               last;
	} result_t;

	// what one character causes: up to three words, in slot order
	localparam int SLOTS = 3;

	typedef struct packed {
		logic [SLOTS-1:0]          slot_valid;
		result_t [SLOTS-1:0]       slot;
	} cmd_t;

	// command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic result_t mk_result(
		input logic [KIND_W-1:0]  kind,
		input logic [CLS_W-1:0]   cls,
		input logic [FID_W-1:0]   fid,
		input logic [START_W-1:0] start,
		input logic [LEN_W-1:0]   len,
		input logic               last
	);
		result_t r;
		r.kind  = kind;
		r.cls   = cls;
		r.fid   = fid;
		r.start = start;
		r.len   = len;
		r.last  = last;
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/flm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flm_front: character classifier and lexer state
// takes one character a cycle while accept is high and builds the command word for the back end
// ----------------------------------------------------------------------------
module flm_front
	import flm_pkg::*;
#(
	parameter int POS_BITS  = 16,
	parameter int NAME_KEEP = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic              final_char,
	output logic                   push,
	output cmd_t                   cmd
);

	localparam int LEN_BITS = (POS_BITS < LEN_W) ? POS_BITS : LEN_W;
	localparam int KEEP_IW  = $clog2(NAME_KEEP);

	localparam logic [CHAR_W-1:0] CH_0     = 16'h0030;
	localparam logic [CHAR_W-1:0] CH_9     = 16'h0039;
	localparam logic [CHAR_W-1:0] CH_DOT   = 16'h002E;
	localparam logic [CHAR_W-1:0] CH_LC_A  = 16'h0061;
	localparam logic [CHAR_W-1:0] CH_LC_Z  = 16'h007A;
	localparam logic [CHAR_W-1:0] CH_UC_A  = 16'h0041;
	localparam logic [CHAR_W-1:0] CH_UC_Z  = 16'h005A;
	localparam logic [CHAR_W-1:0] CH_US    = 16'h005F;
	localparam logic [CHAR_W-1:0] CH_BANG  = 16'h0021;
	localparam logic [CHAR_W-1:0] CH_EQ    = 16'h003D;
	localparam logic [CHAR_W-1:0] CH_GT    = 16'h003E;
	localparam logic [CHAR_W-1:0] CH_LT    = 16'h003C;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 16'h002B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 16'h002D;
	localparam logic [CHAR_W-1:0] CH_STAR  = 16'h002A;
	localparam logic [CHAR_W-1:0] CH_SLASH = 16'h002F;
	localparam logic [CHAR_W-1:0] CH_PCT   = 16'h0025;
	localparam logic [CHAR_W-1:0] CH_CARET = 16'h005E;
	localparam logic [CHAR_W-1:0] CH_LPAR  = 16'h0028;
	localparam logic [CHAR_W-1:0] CH_RPAR  = 16'h0029;
	localparam logic [CHAR_W-1:0] CH_LBRK  = 16'h005B;
	localparam logic [CHAR_W-1:0] CH_RBRK  = 16'h005D;
	localparam logic [CHAR_W-1:0] CH_COMMA = 16'h002C;
	localparam logic [CHAR_W-1:0] CH_COLON = 16'h003A;
	localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_NUM,
		MODE_IDENT,
		MODE_BANG
	} mode_t;

	typedef logic [NAME_KEEP-1:0][CHAR_W-1:0] prefix_t;

	mode_t                mode_q, mode_d;
	logic [POS_BITS-1:0]  tok_start_q, tok_start_d;
	logic [LEN_BITS-1:0]  tok_len_q, tok_len_d;
	logic [POS_BITS-1:0]  char_pos_q, char_pos_d;
	logic                 skip_q, skip_d;
	prefix_t              prefix_q, prefix_d;

	logic                 c_num, c_alpha, c_ident, c_single;
	logic [CLS_W-1:0]     single_cls;
	logic                 done, bad;

	function automatic logic [FID_W-1:0] lookup(input prefix_t pre,
			input logic [LEN_BITS-1:0] len);
		logic [FID_W-1:0] fid;
		logic             same;
		fid = '0;
		for (int k = FN_COUNT - 1; k >= 0; k--) begin
			same = (LEN_BITS'(FN_LEN[k]) == len);
			for (int i = 0; i < FN_MAX; i++) begin
				if (i < int'(FN_LEN[k]) && pre[i] != {8'h00, FN_CHARS[k][i]})
					same = 1'b0;
			end
			if (same)
				fid = FID_W'(k + 1);
		end
		return fid;
	endfunction

	// pending token as it is closed
	function automatic result_t flush_rec(input mode_t mode,
			input logic [POS_BITS-1:0] start, input logic [LEN_BITS-1:0] len,
			input logic [FID_W-1:0] fid);
		result_t r;
		case (mode)
			MODE_IDENT: r = mk_result(KIND_TOKEN, (fid != '0) ? CLS_FUNC : CLS_VALUE, fid,
				START_W'(start), LEN_W'(len), 1'b0);
			MODE_BANG:  r = mk_result(KIND_TOKEN, CLS_COMPARE, '0, START_W'(start),
				LEN_W'(1), 1'b0);
			default:    r = mk_result(KIND_TOKEN, CLS_VALUE, '0, START_W'(start),
				LEN_W'(len), 1'b0);
		endcase
		return r;
	endfunction

	function automatic logic [LEN_BITS-1:0] grow(input logic [LEN_BITS-1:0] len);
		return (len == '1) ? len : len + 1'b1;
	endfunction

	assign c_num   = (char_code inside {[CH_0:CH_9]}) || (char_code == CH_DOT);
	assign c_alpha = (char_code inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z]});
	assign c_ident = c_alpha || (char_code inside {[CH_0:CH_9]}) || (char_code == CH_US);

	// one-character tokens
	always_comb begin
		c_single   = 1'b1;
		single_cls = CLS_VALUE;
		case (char_code) inside
			CH_EQ, CH_GT, CH_LT:              single_cls = CLS_COMPARE;
			CH_PLUS, CH_MINUS:                single_cls = CLS_ADD;
			CH_STAR, CH_SLASH, CH_PCT:        single_cls = CLS_MUL;
			CH_CARET:                         single_cls = CLS_POWER;
			CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK: single_cls = CLS_BRACKET;
			CH_COMMA, CH_COLON:               single_cls = CLS_SEP;
			default:                          c_single = 1'b0;
		endcase
	end

	always_comb begin
		mode_d      = mode_q;
		tok_start_d = tok_start_q;
		tok_len_d   = tok_len_q;
		char_pos_d  = char_pos_q;
		skip_d      = skip_q;
		prefix_d    = prefix_q;
		cmd         = '0;
		done        = 1'b0;
		bad         = 1'b0;
		if (accept) begin
			if (skip_q) begin
				if (final_char) begin
					mode_d      = MODE_IDLE;
					tok_start_d = '0;
					tok_len_d   = '0;
					char_pos_d  = '0;
					skip_d      = 1'b0;
				end
			end else begin
				// continue or close the pending token
				case (mode_q)
					MODE_NUM: begin
						if (c_num) begin
							tok_len_d = grow(tok_len_q);
							done      = 1'b1;
						end
					end
					MODE_IDENT: begin
						if (c_ident) begin
							if (tok_len_q < LEN_BITS'(NAME_KEEP))
								prefix_d[tok_len_q[KEEP_IW-1:0]] = char_code;
							tok_len_d = grow(tok_len_q);
							done      = 1'b1;
						end
					end
					MODE_BANG: begin
						if (char_code == CH_EQ) begin
							cmd.slot_valid[0] = 1'b1;
							cmd.slot[0] = mk_result(KIND_TOKEN, CLS_COMPARE, '0,
								START_W'(tok_start_q), LEN_W'(2), 1'b0);
							mode_d = MODE_IDLE;
							done   = 1'b1;
						end
					end
					default: ;
				endcase
				if (!done && mode_q != MODE_IDLE) begin
					cmd.slot_valid[0] = 1'b1;
					cmd.slot[0] = flush_rec(mode_q, tok_start_q, tok_len_q,
						lookup(prefix_q, tok_len_q));
				end
				// start something new
				if (!done) begin
					mode_d = MODE_IDLE;
					if (c_num) begin
						mode_d      = MODE_NUM;
						tok_start_d = char_pos_q;
						tok_len_d   = LEN_BITS'(1);
					end else if (c_alpha || char_code == CH_US) begin
						mode_d      = MODE_IDENT;
						tok_start_d = char_pos_q;
						tok_len_d   = LEN_BITS'(1);
						prefix_d[0] = char_code;
					end else if (char_code == CH_BANG) begin
						mode_d      = MODE_BANG;
						tok_start_d = char_pos_q;
						tok_len_d   = LEN_BITS'(1);
					end else if (c_single) begin
						cmd.slot_valid[1] = 1'b1;
						cmd.slot[1] = mk_result(KIND_TOKEN, single_cls, '0,
							START_W'(char_pos_q), LEN_W'(1), 1'b0);
					end else if (char_code != CH_SPACE) begin
						bad = 1'b1;
						cmd.slot_valid[1] = 1'b1;
						cmd.slot[1] = mk_result(KIND_ERROR, CLS_VALUE, '0,
							START_W'(char_pos_q), LEN_W'(1), 1'b1);
					end
				end
				if (bad) begin
					if (final_char) begin
						mode_d      = MODE_IDLE;
						tok_start_d = '0;
						tok_len_d   = '0;
						char_pos_d  = '0;
					end else begin
						skip_d = 1'b1;
					end
				end else begin
					char_pos_d = char_pos_q + 1'b1;
					if (final_char) begin
						if (mode_d != MODE_IDLE) begin
							cmd.slot_valid[1] = 1'b1;
							cmd.slot[1] = flush_rec(mode_d, tok_start_d, tok_len_d,
								lookup(prefix_d, tok_len_d));
						end
						cmd.slot_valid[2] = 1'b1;
						cmd.slot[2] = mk_result(KIND_END, CLS_VALUE, '0,
							START_W'(char_pos_q), '0, 1'b1);
						mode_d      = MODE_IDLE;
						tok_start_d = '0;
						tok_len_d   = '0;
						char_pos_d  = '0;
					end
				end
			end
		end
	end

	assign push = |cmd.slot_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			tok_start_q <= '0;
			tok_len_q   <= '0;
			char_pos_q  <= '0;
			skip_q      <= 1'b0;
		end else begin
			mode_q      <= mode_d;
			tok_start_q <= tok_start_d;
			tok_len_q   <= tok_len_d;
			char_pos_q  <= char_pos_d;
			skip_q      <= skip_d;
		end
	end

	// name characters, no reset
	always_ff @(posedge clk) begin
		prefix_q <= prefix_d;
	end

`ifndef SYNTHESIS
	a_fin_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && final_char) |=> (mode_q == MODE_IDLE && char_pos_q == '0 && !skip_q))
		else $error("lexer state not restarted after last character");
`endif

endmodule
`default_nettype wire

/* rtl/flm_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flm_queue: short command queue between front and back
// register-based fifo, write at tail, registered-array read at head
// ----------------------------------------------------------------------------
module flm_queue
	import flm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_data,
	input  wire logic pop,
	output cmd_t      head,
	output qstat_t    stat
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("command queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("command queue read while empty");
`endif

endmodule
`default_nettype wire

/* rtl/flm_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flm_back: result sequencer
// walks the valid slots of the head command, one word per cycle unless
// out_stall holds a loaded word, into the output register
// ----------------------------------------------------------------------------
module flm_back
	import flm_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cmd_t   head,
	input  wire qstat_t stat,
	output logic        pop,
	input  wire logic   out_stall,
	output logic        out_valid,
	output result_t     result
);

	logic [SLOTS-1:0] done_q;
	logic [SLOTS-1:0] pending, pick, remain;
	logic             out_valid_q, load;
	result_t          result_q, pick_res;

	assign pending = head.slot_valid & ~done_q;

	// lowest pending slot first
	always_comb begin
		pick     = '0;
		pick_res = head.slot[0];
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (pending[i]) begin
				pick     = SLOTS'(1) << i;
				pick_res = head.slot[i];
			end
		end
	end

	assign remain = pending & ~pick;
	assign load   = !stat.empty && (!out_valid_q || !out_stall);
	assign pop    = load && (remain == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q      <= '0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (pop)
				done_q <= '0;
			else if (load)
				done_q <= done_q | pick;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			result_q <= pick_res;
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

`ifndef SYNTHESIS
	a_head_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (pending != '0))
		else $error("queued command without a pending word");
`endif

endmodule
`default_nettype wire

/* rtl/formula_lexer.sv */
`timescale 1ns / 1ps
`default_nettype none
// path: each word of a character is written into the command queue and then
//   loaded into the output register
// throughput, out_stall low: one character per cycle while each gives at most one word;
//   a character that closes a token and ends the formula gives up to three words,
//   drained one per cycle from a 4-deep command queue; input stalls only on a full queue
// reset: arst_n clears lexer state, queue pointers and output valid at once
// ----------------------------------------------------------------------------
// formula_lexer: streaming tokenizer for arithmetic formulas
// front end classifies characters and tracks the open token, back end turns
// each queued command into tokens, error and end words
// ----------------------------------------------------------------------------
module formula_lexer
	import flm_pkg::*;
#(
	parameter int POS_BITS  = 16,
	parameter int NAME_KEEP = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// character word
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [CHAR_W-1:0]  char_code,
	input  wire logic               final_char,
	// result word
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [KIND_W-1:0]       kind,
	output logic [CLS_W-1:0]        token_class,
	output logic [FID_W-1:0]        function_id,
	output logic [START_W-1:0]      start_pos,
	output logic [LEN_W-1:0]        token_len,
	output logic                    last_result
);

	logic    accept;
	logic    push, pop;
	cmd_t    cmd, head;
	qstat_t  stat;
	result_t result;

	// front stalls only on a full queue, so it keeps taking characters
	// while the back end still holds a word in its output register
	assign in_stall = stat.full;
	assign accept   = in_valid && !in_stall;

	flm_front #(
		.POS_BITS  (POS_BITS),
		.NAME_KEEP (NAME_KEEP)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.char_code  (char_code),
		.final_char (final_char),
		.push       (push),
		.cmd        (cmd)
	);

	// commands without any word (spaces, dropped tail) are never queued
	flm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cmd),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	flm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.result    (result)
	);

	// unpack the output register onto the field ports
	assign kind        = result.kind;
	assign token_class = result.cls;
	assign function_id = result.fid;
	assign start_pos   = result.start;
	assign token_len   = result.len;
	assign last_result = result.last;

endmodule
`default_nettype wire

/* verif/formula_lexer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// formula_lexer_checker: predicts and compares the result words of the lexer
// follows each accepted character word with its own copy of the lexer state
// and compares each accepted result word with the oldest word still due
// ----------------------------------------------------------------------------
module formula_lexer_checker
	import flm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic [CHAR_W-1:0]  char_code,
	input  wire logic               final_char,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic [KIND_W-1:0]  kind,
	input  wire logic [CLS_W-1:0]   token_class,
	input  wire logic [FID_W-1:0]   function_id,
	input  wire logic [START_W-1:0] start_pos,
	input  wire logic [LEN_W-1:0]   token_len,
	input  wire logic               last_result,
	output int                      pending,
	output int                      fail_count,
	output int                      words_checked,
	output int                      error_words,
	output int                      end_words
);

	localparam int          NAME_KEEP  = 5;
	localparam logic [15:0] LEN_CAP    = 16'hFFFF;

	typedef enum logic [1:0] {LEX_IDLE, LEX_NUMBER, LEX_NAME, LEX_BANG} lex_mode_t;

	lex_mode_t   mode;
	logic [15:0] tok_start;
	logic [15:0] tok_len;
	logic [15:0] char_pos;
	logic [15:0] name_buf [NAME_KEEP];
	logic        skip_rest;
	result_t     words_due [$];

	function automatic logic is_digit(input logic [15:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [15:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	// function id of the identifier held in name_buf, zero for a variable
	function automatic logic [FID_W-1:0] match_name();
		int   k;
		int   i;
		logic same;
		if (tok_len > NAME_KEEP) return '0;
		for (k = 0; k < FN_COUNT; k++) begin
			if (FN_LEN[k] == tok_len) begin
				same = 1'b1;
				for (i = 0; i < FN_LEN[k]; i++)
					if (name_buf[i] != {8'h00, FN_CHARS[k][i]}) same = 1'b0;
				if (same) return FID_W'(k + 1);
			end
		end
		return '0;
	endfunction

	task automatic push_word(
		input logic [KIND_W-1:0]  k,
		input logic [CLS_W-1:0]   cls,
		input logic [FID_W-1:0]   fid,
		input logic [START_W-1:0] start,
		input logic [LEN_W-1:0]   len,
		input logic               last
	);
		result_t w;
		w.kind  = k;
		w.cls   = cls;
		w.fid   = fid;
		w.start = start;
		w.len   = len;
		w.last  = last;
		words_due.push_back(w);
	endtask

	task automatic close_token();
		logic [FID_W-1:0] fid;
		case (mode)
			LEX_NUMBER: push_word(KIND_TOKEN, CLS_VALUE, '0, tok_start, tok_len, 1'b0);
			LEX_NAME: begin
				fid = match_name();
				push_word(KIND_TOKEN, (fid != '0) ? CLS_FUNC : CLS_VALUE, fid, tok_start,
					tok_len, 1'b0);
			end
			LEX_BANG: push_word(KIND_TOKEN, CLS_COMPARE, '0, tok_start, 16'd1, 1'b0);
			default: ;
		endcase
		mode = LEX_IDLE;
	endtask

	task automatic restart_lexer();
		mode      = LEX_IDLE;
		tok_start = '0;
		tok_len   = '0;
		char_pos  = '0;
		skip_rest = 1'b0;
	endtask

	task automatic grow_token();
		if (tok_len != LEN_CAP) tok_len = tok_len + 16'd1;
	endtask

	task automatic lex_char(input logic [15:0] c, input logic fin);
		logic [15:0]      p;
		logic             taken;
		logic             is_op;
		logic [CLS_W-1:0] cls;
		p     = char_pos;
		taken = 1'b0;
		is_op = 1'b0;
		cls   = CLS_VALUE;
		// after an unknown character only the last one of the formula matters
		if (skip_rest) begin
			if (fin) restart_lexer();
			return;
		end
		case (mode)
			LEX_NUMBER: begin
				if (is_digit(c) || c == ".") begin
					grow_token();
					taken = 1'b1;
				end else begin
					close_token();
				end
			end
			LEX_NAME: begin
				if (is_alpha(c) || is_digit(c) || c == "_") begin
					if (tok_len < NAME_KEEP) name_buf[tok_len[2:0]] = c;
					grow_token();
					taken = 1'b1;
				end else begin
					close_token();
				end
			end
			LEX_BANG: begin
				if (c == "=") begin
					push_word(KIND_TOKEN, CLS_COMPARE, '0, tok_start, 16'd2, 1'b0);
					mode  = LEX_IDLE;
					taken = 1'b1;
				end else begin
					close_token();
				end
			end
			default: ;
		endcase
		if (!taken) begin
			if (is_digit(c) || c == ".") begin
				mode      = LEX_NUMBER;
				tok_start = p;
				tok_len   = 16'd1;
			end else if (is_alpha(c) || c == "_") begin
				mode        = LEX_NAME;
				tok_start   = p;
				tok_len     = 16'd1;
				name_buf[0] = c;
			end else begin
				case (c)
					"!": begin
						mode      = LEX_BANG;
						tok_start = p;
						tok_len   = 16'd1;
					end
					"=", "<", ">": begin
						is_op = 1'b1;
						cls   = CLS_COMPARE;
					end
					"+", "-": begin
						is_op = 1'b1;
						cls   = CLS_ADD;
					end
					"*", "/", "%": begin
						is_op = 1'b1;
						cls   = CLS_MUL;
					end
					"^": begin
						is_op = 1'b1;
						cls   = CLS_POWER;
					end
					"(", ")", "[", "]": begin
						is_op = 1'b1;
						cls   = CLS_BRACKET;
					end
					",", ":": begin
						is_op = 1'b1;
						cls   = CLS_SEP;
					end
					" ": ;
					default: begin
						push_word(KIND_ERROR, CLS_VALUE, '0, p, 16'd1, 1'b1);
						if (fin) restart_lexer();
						else skip_rest = 1'b1;
						return;
					end
				endcase
				if (is_op) push_word(KIND_TOKEN, cls, '0, p, 16'd1, 1'b0);
			end
		end
		char_pos = p + 16'd1;
		if (fin) begin
			close_token();
			push_word(KIND_END, CLS_VALUE, '0, p, '0, 1'b1);
			restart_lexer();
		end
	endtask

	task automatic report_fault(input string msg);
		$display("%0t ns  lexer check: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_word();
		result_t want;
		if (words_due.size() == 0) begin
			report_fault($sformatf("word with nothing due: kind %0d start %0d",
				kind, start_pos));
			return;
		end
		want = words_due.pop_front();
		words_checked++;
		if (want.kind == KIND_ERROR) error_words++;
		if (want.kind == KIND_END) end_words++;
		if (kind !== want.kind)
			report_fault($sformatf("kind %0d, due %0d (start %0d)", kind, want.kind,
				want.start));
		if (token_class !== want.cls)
			report_fault($sformatf("token_class %0d, due %0d (start %0d)", token_class,
				want.cls, want.start));
		if (function_id !== want.fid)
			report_fault($sformatf("function_id %0d, due %0d (start %0d)", function_id,
				want.fid, want.start));
		if (start_pos !== want.start)
			report_fault($sformatf("start_pos %0d, due %0d", start_pos, want.start));
		if (token_len !== want.len)
			report_fault($sformatf("token_len %0d, due %0d (start %0d)", token_len,
				want.len, want.start));
		if (last_result !== want.last)
			report_fault($sformatf("last_result %0d, due %0d (start %0d)", last_result,
				want.last, want.start));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_lexer();
			foreach (name_buf[i]) name_buf[i] = '0;
			words_due.delete();
			pending       = 0;
			fail_count    = 0;
			words_checked = 0;
			error_words   = 0;
			end_words     = 0;
		end else begin
			if (in_valid && !in_stall) lex_char(char_code, final_char);
			if (out_valid && !out_stall) check_word();
			pending = words_due.size();
		end
	end

endmodule

/* verif/formula_lexer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// formula_lexer_test: randomized test of the formula lexer
// feeds formulas as character words, corner cases first, then random formulas
// under three idling patterns; a checker beside the block predicts every
// result word and compares it as it leaves
// ----------------------------------------------------------------------------
module formula_lexer_test
	import flm_pkg::*;
();

	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_ITEMS = 130;
	localparam int DRAIN_CYCLES = 8;      // output register plus the command queue

	// character pools for random formulas
	localparam string OPERATORS  = "=<>+-*/%^()[],:!";
	localparam string NAME_FIRST = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	localparam string NAME_REST  =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [CHAR_W-1:0]  char_code;
	logic               final_char;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [KIND_W-1:0]  kind;
	logic [CLS_W-1:0]   token_class;
	logic [FID_W-1:0]   function_id;
	logic [START_W-1:0] start_pos;
	logic [LEN_W-1:0]   token_len;
	logic               last_result;

	// checker status
	int pending;
	int fail_count;
	int words_checked;
	int error_words;
	int end_words;

	// idling odds in percent, changed per phase
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// stimulus bookkeeping
	int          chars_sent;
	int          formulas_sent;
	int          random_chars;
	logic [15:0] formula [$];

	formula_lexer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_code   (char_code),
		.final_char  (final_char),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.token_class (token_class),
		.function_id (function_id),
		.start_pos   (start_pos),
		.token_len   (token_len),
		.last_result (last_result)
	);

	formula_lexer_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_code     (char_code),
		.final_char    (final_char),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.token_class   (token_class),
		.function_id   (function_id),
		.start_pos     (start_pos),
		.token_len     (token_len),
		.last_result   (last_result),
		.pending       (pending),
		.fail_count    (fail_count),
		.words_checked (words_checked),
		.error_words   (error_words),
		.end_words     (end_words)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#1000000;
		$display("simulation failed");
		$finish;
	end

	// receiver stalls at random, odds set by the running phase
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// one character word: optional idle gap, then hold until taken
	task automatic send_char(input logic [15:0] c, input logic fin);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		char_code  <= c;
		final_char <= fin;
		// payload stays put while stalled
		do @(posedge clk); while (in_stall);
		chars_sent++;
	endtask

	// the whole formula buffer, last character marked
	task automatic send_formula();
		foreach (formula[i]) send_char(formula[i], i == formula.size() - 1);
		formulas_sent++;
	endtask

	task automatic send_text(input string s);
		int i;
		formula.delete();
		for (i = 0; i < s.len(); i++) formula.push_back({8'h00, s[i]});
		send_formula();
	endtask

	function automatic logic [15:0] pick_char(input string pool);
		return {8'h00, pool[$urandom_range(0, pool.len() - 1)]};
	endfunction

	// appends one well-formed token to the formula buffer
	task automatic add_token();
		int n;
		int i;
		int k;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				// number: digits with the odd dot
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++)
					if ($urandom_range(0, 6) == 0) formula.push_back({8'h00, "."});
					else formula.push_back({8'h00, "0"} + 16'($urandom_range(0, 9)));
			end
			3, 4: begin
				// function name, sometimes stretched into a plain variable
				k = $urandom_range(0, FN_COUNT - 1);
				for (i = 0; i < FN_LEN[k]; i++) formula.push_back({8'h00, FN_CHARS[k][i]});
				if ($urandom_range(0, 3) == 0) formula.push_back(pick_char(NAME_REST));
			end
			5: begin
				// random identifier, short or long
				n = $urandom_range(1, 8);
				formula.push_back(pick_char(NAME_FIRST));
				for (i = 1; i < n; i++) formula.push_back(pick_char(NAME_REST));
			end
			6, 7: formula.push_back(pick_char(OPERATORS));
			8: begin
				formula.push_back({8'h00, "!"});
				formula.push_back({8'h00, "="});
			end
			default: formula.push_back({8'h00, " "});
		endcase
	endtask

	// mostly well-formed formulas; a few carry an unknown character or are noise
	// useful counts the characters the lexer actually works on
	task automatic make_formula(output int useful);
		int n;
		int i;
		int bad_at;
		formula.delete();
		n = $urandom_range(1, 6);
		for (i = 0; i < n; i++) add_token();
		useful = formula.size();
		case ($urandom_range(0, 19))
			0, 1: begin
				// one arbitrary wide character somewhere, rest of formula dropped
				bad_at         = $urandom_range(0, formula.size() - 1);
				formula[bad_at] = 16'($urandom_range(0, 65535));
				useful         = bad_at + 1 + int'(bad_at < formula.size() - 1);
			end
			2: begin
				// pure noise: wide codes and ascii characters
				formula.delete();
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++)
					if ($urandom_range(0, 1) != 0) formula.push_back(16'($urandom_range(0, 65535)));
					else formula.push_back(16'($urandom_range(0, 127)));
				useful = n;
			end
			default: ;
		endcase
	endtask

	task automatic run_random(input int upto);
		int useful;
		while (random_chars < upto) begin
			make_formula(useful);
			send_formula();
			random_chars += useful;
		end
	endtask

	// sender holds off until every due word has left
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		char_code  = '0;
		final_char = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phase one: sender idles now and then, receiver stalls a lot
		send_idle_pct  = 13;
		recv_stall_pct = 65;

		// function, bracket, identifier with underscore, "!=", number from a dot
		send_text("floor(x_9)!=.5");
		// lone bang inside a formula and as its last character
		send_text("a!b");
		send_text("!");
		// long identifier closed by an unknown character, rest skipped
		send_text("abcdef#1");
		// unknown last character right after a number: error, no end word
		send_text("7$");
		// extremes of the character code, both unknown and last
		send_char(16'hFFFF, 1'b1);
		send_char(16'h0000, 1'b1);
		formulas_sent += 2;

		run_random(40);
		wait_drained();

		// phase two: sender idles a lot, receiver stalls now and then
		send_idle_pct  = 65;
		recv_stall_pct = 13;
		run_random(85);
		wait_drained();

		// phase three: no idling on either side
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random(RANDOM_ITEMS);

		// let everything due come out, then a little extra for strays
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d character words in %0d formulas (%0d random)",
			chars_sent, formulas_sent, random_chars);
		$display("result words compared: %0d, of them %0d errors and %0d ends of formula",
			words_checked, error_words, end_words);
		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
